// ===== rtl/core/tdw_pkg.sv =====
// ----------------------------------------------------------------------------
// Terminal display width counter package
// Shared types and constants for the UTF-16 display width counter.
// ----------------------------------------------------------------------------
package tdw_pkg;

    localparam int TOTAL_BITS_DEFAULT = 16;

    localparam logic [15:0] ESC_UNIT      = 16'h001B;
    localparam logic [15:0] CSI_OPEN      = 16'h005B;
    localparam logic [15:0] CSI_FINAL_LO  = 16'h0040;
    localparam logic [15:0] CSI_FINAL_HI  = 16'h007E;
    localparam logic [15:0] HIGH_SURR_LO  = 16'hD800;
    localparam logic [15:0] HIGH_SURR_HI  = 16'hDBFF;
    localparam logic [15:0] LOW_SURR_LO   = 16'hDC00;
    localparam logic [15:0] LOW_SURR_HI   = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE     = 21'h10000;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        last;
    } tdw_in_t;

    typedef struct packed {
        logic [1:0]  added_width;
        logic [15:0] total_width;
        logic        saturated;
        logic        done_res;
    } tdw_out_t;

    typedef struct packed {
        logic       in_escape;
        logic       pending_escape;
        logic       pending_high;
        logic [9:0] high_payload;
    } tdw_parse_t;

    typedef struct packed {
        logic [1:0] added;
        tdw_parse_t parse_next;
    } tdw_step_t;

endpackage

// ===== rtl/core/tdw_decode.sv =====
// ----------------------------------------------------------------------------
// Code unit decoder
// Classifies one UTF-16 code unit against the escape and surrogate state and
// gives the columns it completes and the next parser state.
// ----------------------------------------------------------------------------
module tdw_decode
    import tdw_pkg::*;
(
    input  tdw_in_t    unit,
    input  tdw_parse_t parse,
    output tdw_step_t  step
);

    function automatic logic [1:0] bmp_width(input logic [15:0] u);
        logic zero;
        logic wide;
        begin
            zero = (u == 16'h0000) ||
                   (u >= 16'h200B && u <= 16'h200D) ||
                   (u == 16'hFEFF) ||
                   (u >= 16'h0300 && u <= 16'h036F);
            wide = (u >= 16'h1100 && u <= 16'h115F) ||
                   (u >= 16'h2E80 && u <= 16'h303E) ||
                   (u >= 16'h3041 && u <= 16'h33FF) ||
                   (u >= 16'h3400 && u <= 16'h4DBF) ||
                   (u >= 16'h4E00 && u <= 16'h9FFF) ||
                   (u >= 16'hA000 && u <= 16'hA4CF) ||
                   (u >= 16'hAC00 && u <= 16'hD7A3) ||
                   (u >= 16'hF900 && u <= 16'hFAFF) ||
                   (u >= 16'hFE30 && u <= 16'hFE4F) ||
                   (u >= 16'hFF00 && u <= 16'hFF60) ||
                   (u >= 16'hFFE0 && u <= 16'hFFE6);
            if (zero)
            begin
                bmp_width = 2'd0;
            end
            else if (wide)
            begin
                bmp_width = 2'd2;
            end
            else
            begin
                bmp_width = 2'd1;
            end
        end
    endfunction

    logic [15:0] u;
    logic [20:0] pair_cp;
    logic [1:0]  pair_width;
    logic        is_high;
    logic        is_low;
    logic        use_fresh;
    logic        flush;
    logic        end_flush;
    logic [1:0]  base;
    tdw_parse_t  nxt;

    assign u       = unit.code_unit;
    assign is_high = (u >= HIGH_SURR_LO) && (u <= HIGH_SURR_HI);
    assign is_low  = (u >= LOW_SURR_LO) && (u <= LOW_SURR_HI);
    assign pair_cp = SUPP_BASE + {1'b0, parse.high_payload, u[9:0]};

    always_comb
    begin
        if ((pair_cp >= 21'h1F300 && pair_cp <= 21'h1FAFF) ||
            (pair_cp >= 21'h20000 && pair_cp <= 21'h3FFFD))
        begin
            pair_width = 2'd2;
        end
        else
        begin
            pair_width = 2'd1;
        end
    end

    always_comb
    begin
        nxt       = parse;
        base      = 2'd0;
        flush     = 1'b0;
        use_fresh = 1'b0;
        if (parse.in_escape)
        begin
            if (u >= CSI_FINAL_LO && u <= CSI_FINAL_HI)
            begin
                nxt.in_escape = 1'b0;
            end
        end
        else if (parse.pending_escape)
        begin
            nxt.pending_escape = 1'b0;
            if (u == CSI_OPEN)
            begin
                nxt.in_escape = 1'b1;
            end
            else
            begin
                flush     = 1'b1;
                use_fresh = 1'b1;
            end
        end
        else if (parse.pending_high)
        begin
            nxt.pending_high = 1'b0;
            if (is_low)
            begin
                base = pair_width;
            end
            else
            begin
                flush     = 1'b1;
                use_fresh = 1'b1;
            end
        end
        else
        begin
            use_fresh = 1'b1;
        end

        if (use_fresh)
        begin
            if (u == ESC_UNIT)
            begin
                nxt.pending_escape = 1'b1;
            end
            else if (is_high)
            begin
                nxt.pending_high = 1'b1;
                nxt.high_payload = u[9:0];
            end
            else
            begin
                base = bmp_width(u);
            end
        end
    end

    assign end_flush = unit.last && (nxt.pending_escape || nxt.pending_high);

    assign step.added      = base + {1'b0, flush} + {1'b0, end_flush};
    assign step.parse_next = nxt;

endmodule

// ===== rtl/core/tdw_accum.sv =====
// ----------------------------------------------------------------------------
// Width accumulator
// Holds the parser state and the saturating column total, and registers the
// result of each request.
// ----------------------------------------------------------------------------
module tdw_accum
    import tdw_pkg::*;
#(
    parameter int TOTAL_BITS = TOTAL_BITS_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  logic       last,
    input  tdw_step_t  step,
    input  logic       result_stall,
    output tdw_parse_t parse,
    output logic       result_valid,
    output tdw_out_t   result
);

    tdw_parse_t              parse_reg;
    tdw_parse_t              parse_next;
    logic [TOTAL_BITS-1:0]   total_reg;
    logic [TOTAL_BITS-1:0]   total_next;
    logic                    over_reg;
    logic                    over_next;
    logic                    result_valid_reg;
    logic                    result_valid_next;
    tdw_out_t                result_reg;
    tdw_out_t                result_next;
    logic [TOTAL_BITS:0]     sum;
    logic [TOTAL_BITS-1:0]   total_sat;
    logic                    over_sat;
    logic [15:0]             report;

    assign sum       = {1'b0, total_reg} + (TOTAL_BITS+1)'(step.added);
    assign total_sat = sum[TOTAL_BITS] ? {TOTAL_BITS{1'b1}} : sum[TOTAL_BITS-1:0];
    assign over_sat  = over_reg | sum[TOTAL_BITS];

    generate
        if (TOTAL_BITS >= 16)
        begin : g_wide
            assign report = total_sat[15:0];
        end
        else
        begin : g_narrow
            assign report = {{(16-TOTAL_BITS){1'b0}}, total_sat};
        end
    endgenerate

    always_comb
    begin
        parse_next = parse_reg;
        total_next = total_reg;
        over_next  = over_reg;
        if (advance)
        begin
            if (last)
            begin
                parse_next = '0;
                total_next = '0;
                over_next  = 1'b0;
            end
            else
            begin
                parse_next = step.parse_next;
                total_next = total_sat;
                over_next  = over_sat;
            end
        end
    end

    always_comb
    begin
        result_next             = result_reg;
        result_valid_next       = result_valid_reg;
        if (advance)
        begin
            result_valid_next       = 1'b1;
            result_next.added_width = step.added;
            result_next.total_width = report;
            result_next.saturated   = over_sat;
            result_next.done_res    = last;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parse_reg        <= '0;
            total_reg        <= '0;
            over_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            parse_reg        <= parse_next;
            total_reg        <= total_next;
            over_reg         <= over_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign parse        = parse_reg;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== rtl/core/terminal_display_width_counter_unit.sv =====
// ----------------------------------------------------------------------------
// Terminal display width counter
// Counts terminal display columns of a UTF-16 string, one code unit per
// request, with escape sequences, surrogate pairs and a saturating total.
//
//   Channel   Direction   Handshake                    Payload
//   unit      in          unit_valid / unit_stall      tdw_in_t
//   result    out         result_valid / result_stall  tdw_out_t
//
// A request is registered at the input and its result is registered in the
// result register; a new request is taken every cycle unless the result stalls.
// The parser state and column total are registered together with the result.
// Reset clears the parser state, the total and both valid flags.
// A stalled result holds any request in the input register, and the input stalls only while
// it holds a request that cannot move on.
// ----------------------------------------------------------------------------
module terminal_display_width_counter_unit
    import tdw_pkg::*;
#(
    parameter int TOTAL_BITS = TOTAL_BITS_DEFAULT
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     unit_valid,
    output logic     unit_stall,
    input  tdw_in_t  unit_data,
    output logic     result_valid,
    input  logic     result_stall,
    output tdw_out_t result
);

    localparam logic [15:0] REPORT_MAX = (TOTAL_BITS >= 16) ? 16'hFFFF :
                                         16'((32'd1 << TOTAL_BITS) - 32'd1);

    logic       in_valid_reg;
    logic       in_valid_next;
    tdw_in_t    in_data_reg;
    tdw_in_t    in_data_next;
    logic       advance;
    tdw_parse_t parse;
    tdw_step_t  step;

    assign advance    = in_valid_reg && (!result_valid || !result_stall);
    assign unit_stall = in_valid_reg && !advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        in_data_next  = in_data_reg;
        if (!unit_stall)
        begin
            in_valid_next = unit_valid;
            in_data_next  = unit_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_data_reg <= in_data_next;
    end

    tdw_decode u_decode
    (
        .unit  (in_data_reg),
        .parse (parse),
        .step  (step)
    );

    tdw_accum #(
        .TOTAL_BITS (TOTAL_BITS)
    ) u_accum
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .last         (in_data_reg.last),
        .step         (step),
        .result_stall (result_stall),
        .parse        (parse),
        .result_valid (result_valid),
        .result       (result)
    );

    // At most one of the escape and surrogate conditions is open at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({parse.in_escape, parse.pending_escape, parse.pending_high}))
        else $error("parser holds more than one open condition");

    // The end of a string leaves the parser clear.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_data_reg.last) |=> (parse == '0))
        else $error("parser state not cleared after end of string");

    // Once saturated, the reported total sits at its maximum.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.saturated) |-> (result.total_width == REPORT_MAX))
        else $error("saturated result does not report the maximum total");

    // A request moves to the result register only when that register is free.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |-> !advance)
        else $error("result overwritten while stalled");

endmodule

// ===== dv/tb_terminal_display_width_counter_unit.sv =====
// ----------------------------------------------------------------------------
// Testbench for the terminal display width counter
// Sends UTF-16 strings one code unit per request and predicts the columns
// that each unit adds and the running total. Directed strings cover the
// character classes, escape sequences, surrogate pairs and saturation.
// Random strings follow, first under one long receiver hold with no sender gaps,
// then with random gaps on the sender side and random stalls on the receiver
// side. Each result is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_terminal_display_width_counter_unit;
    import tdw_pkg::*;

    localparam int          TOTAL_BITS   = TOTAL_BITS_DEFAULT;
    localparam int          CLK_PERIOD   = 20;
    localparam int unsigned RANDOM_ITEMS = 1000;
    localparam int unsigned CYCLE_LIMIT  = 1000000;
    localparam int unsigned DRAIN_CYCLES = 10;
    localparam int unsigned LONG_HOLD    = 200;
    localparam longint unsigned COLUMN_MAX = (64'd1 << TOTAL_BITS) - 64'd1;

    localparam int unsigned WIDE_LO [13] = '{
        'h1100, 'h2E80, 'h3041, 'h3400, 'h4E00, 'hA000, 'hAC00,
        'hF900, 'hFE30, 'hFF00, 'hFFE0, 'h1F300, 'h20000
    };
    localparam int unsigned WIDE_HI [13] = '{
        'h115F, 'h303E, 'h33FF, 'h4DBF, 'h9FFF, 'hA4CF, 'hD7A3,
        'hFAFF, 'hFE4F, 'hFF60, 'hFFE6, 'h1FAFF, 'h3FFFD
    };

    typedef logic [15:0] unit_seq_t[$];

    logic     clk;
    logic     rst_n;
    logic     unit_valid;
    logic     unit_stall;
    tdw_in_t  unit_data;
    logic     result_valid;
    logic     result_stall;
    tdw_out_t result;

    tdw_out_t        width_expect_q[$];
    int unsigned     mismatch_count = 0;
    int unsigned     cycle_count = 0;
    bit              sender_gaps = 1'b1;
    bit              receiver_stalls = 1'b1;
    bit              pressure_hold = 1'b0;

    logic            csi_active;
    logic            esc_waiting;
    logic            high_waiting;
    logic [9:0]      high_bits;
    longint unsigned column_sum;
    logic            column_clipped;

    terminal_display_width_counter_unit #(
        .TOTAL_BITS (TOTAL_BITS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .unit_valid   (unit_valid),
        .unit_stall   (unit_stall),
        .unit_data    (unit_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic void clear_parser();
        csi_active     = 1'b0;
        esc_waiting    = 1'b0;
        high_waiting   = 1'b0;
        high_bits      = '0;
        column_sum     = 0;
        column_clipped = 1'b0;
    endfunction

    function automatic int unsigned code_point_columns(input int unsigned cp);
        int i;
        if (cp == 0 || (cp >= 'h200B && cp <= 'h200D) || cp == 'hFEFF ||
            (cp >= 'h0300 && cp <= 'h036F))
            return 0;
        for (i = 0; i < 13; i++)
            if (cp >= WIDE_LO[i] && cp <= WIDE_HI[i])
                return 2;
        return 1;
    endfunction

    function automatic int unsigned open_unit(input logic [15:0] cu);
        if (cu == ESC_UNIT)
        begin
            esc_waiting = 1'b1;
            return 0;
        end
        if (cu >= HIGH_SURR_LO && cu <= HIGH_SURR_HI)
        begin
            high_waiting = 1'b1;
            high_bits    = cu[9:0];
            return 0;
        end
        return code_point_columns(cu);
    endfunction

    function automatic tdw_out_t predict_columns(input tdw_in_t req);
        int unsigned     added;
        int unsigned     cp;
        longint unsigned sum;
        tdw_out_t        exp_res;
        added = 0;
        if (csi_active)
        begin
            if (req.code_unit >= CSI_FINAL_LO && req.code_unit <= CSI_FINAL_HI)
                csi_active = 1'b0;
        end
        else if (esc_waiting)
        begin
            esc_waiting = 1'b0;
            if (req.code_unit == CSI_OPEN)
                csi_active = 1'b1;
            else
                added = 1 + open_unit(req.code_unit);
        end
        else if (high_waiting)
        begin
            high_waiting = 1'b0;
            if (req.code_unit >= LOW_SURR_LO && req.code_unit <= LOW_SURR_HI)
            begin
                cp    = 32'(SUPP_BASE + {high_bits, req.code_unit[9:0]});
                added = code_point_columns(cp);
            end
            else
            begin
                added = 1 + open_unit(req.code_unit);
            end
        end
        else
        begin
            added = open_unit(req.code_unit);
        end
        if (req.last && (esc_waiting || high_waiting))
            added++;
        sum = column_sum + 64'(added);
        if (sum > COLUMN_MAX)
        begin
            sum            = COLUMN_MAX;
            column_clipped = 1'b1;
        end
        column_sum = sum;
        exp_res.added_width = 2'(added);
        exp_res.total_width = 16'(column_sum);
        exp_res.saturated   = column_clipped;
        exp_res.done_res    = req.last;
        if (req.last)
            clear_parser();
        return exp_res;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int unsigned pick_near_range(input int unsigned lo,
                                                    input int unsigned hi);
        case ($urandom_range(0, 5))
            0:       return lo;
            1:       return hi;
            2:       return lo - 1;
            3:       return hi + 1;
            default: return $urandom_range(lo, hi);
        endcase
    endfunction

    function automatic unit_seq_t build_random_string();
        unit_seq_t   s;
        int unsigned len;
        int unsigned kind;
        int unsigned idx;
        int unsigned cp;
        int unsigned off;
        int unsigned n;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
        while (s.size() < len)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 30)
            begin
                s.push_back(16'($urandom_range('h20, 'h7E)));
            end
            else if (kind < 48)
            begin
                idx = $urandom_range(0, 10);
                s.push_back(16'(pick_near_range(WIDE_LO[idx], WIDE_HI[idx])));
            end
            else if (kind < 58)
            begin
                idx = $urandom_range(11, 13);
                if (idx == 13)
                    cp = $urandom_range('h10000, 'h10FFFF);
                else
                    cp = pick_near_range(WIDE_LO[idx], WIDE_HI[idx]);
                off = cp - 'h10000;
                s.push_back(16'(HIGH_SURR_LO + (off >> 10)));
                s.push_back(16'(LOW_SURR_LO + (off & 'h3FF)));
            end
            else if (kind < 70)
            begin
                s.push_back(ESC_UNIT);
                s.push_back(CSI_OPEN);
                n = $urandom_range(0, 3);
                repeat (n)
                    s.push_back(($urandom_range(0, 4) == 0) ?
                                16'($urandom_range('h80, 'hFFFF)) :
                                16'($urandom_range('h20, 'h3F)));
                if ($urandom_range(0, 5) != 0)
                    s.push_back(16'($urandom_range(CSI_FINAL_LO, CSI_FINAL_HI)));
            end
            else if (kind < 76)
            begin
                s.push_back(ESC_UNIT);
            end
            else if (kind < 82)
            begin
                s.push_back(16'($urandom_range(HIGH_SURR_LO, HIGH_SURR_HI)));
            end
            else if (kind < 87)
            begin
                s.push_back(16'($urandom_range(LOW_SURR_LO, LOW_SURR_HI)));
            end
            else if (kind < 94)
            begin
                case ($urandom_range(0, 7))
                    0:       s.push_back(16'h0000);
                    1:       s.push_back(16'($urandom_range('h200A, 'h200E)));
                    2:       s.push_back(16'hFEFF);
                    3:       s.push_back(16'h02FF);
                    4:       s.push_back(16'h0370);
                    default: s.push_back(16'($urandom_range('h0300, 'h036F)));
                endcase
            end
            else
            begin
                s.push_back(16'($urandom));
            end
        end
        return s;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("[%0d] %s: expected %0h, got %0h", cycle_count, what, want, got);
        mismatch_count++;
    endtask

    task automatic send_unit(input logic [15:0] cu, input logic lst);
        int unsigned gap;
        tdw_in_t     req;
        gap           = sender_gaps ? pick_gap() : 0;
        req.code_unit = cu;
        req.last      = lst;
        if (gap != 0)
        begin
            unit_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        unit_valid <= 1'b1;
        unit_data  <= req;
        do
            @(posedge clk);
        while (unit_stall);
        width_expect_q.push_back(predict_columns(req));
    endtask

    task automatic send_string(input unit_seq_t s);
        int i;
        for (i = 0; i < s.size(); i++)
            send_unit(s[i], i == s.size() - 1);
    endtask

    task automatic test_character_classes();
        send_string('{16'h0000, 16'h036F, 16'hFEFF, 16'h1100, 16'hFFFF});
    endtask

    task automatic test_escape_sequences();
        send_string('{ESC_UNIT, CSI_OPEN, 16'h0031, CSI_FINAL_HI, ESC_UNIT, 16'h4E00,
                      ESC_UNIT});
        send_string('{ESC_UNIT, CSI_OPEN, 16'h0032});
    endtask

    task automatic test_surrogate_pairs();
        send_string('{16'hD83C, 16'hDF00, HIGH_SURR_HI, LOW_SURR_HI, HIGH_SURR_LO,
                      16'h0041, LOW_SURR_LO, 16'hD840});
    endtask

    task automatic test_column_saturation();
        int i;
        sender_gaps = 1'b0;
        receiver_stalls <= 1'b0;
        for (i = 0; i < 32767; i++)
            send_unit(16'h4E00 + 16'(i[11:0]), 1'b0);
        send_unit(16'h0041, 1'b0);
        send_unit(ESC_UNIT, 1'b0);
        send_unit(16'hAC00, 1'b0);
        send_unit(16'h0041, 1'b1);
        receiver_stalls <= 1'b1;
        sender_gaps = 1'b1;
    endtask

    task automatic test_result_backpressure();
        int unsigned sent;
        unit_seq_t   s;
        sent = 0;
        sender_gaps = 1'b0;
        pressure_hold <= 1'b1;
        while (sent < 80)
        begin
            s = build_random_string();
            send_string(s);
            sent += s.size();
        end
        sender_gaps = 1'b1;
    endtask

    task automatic test_random_strings();
        int unsigned sent;
        unit_seq_t   s;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            sender_gaps = ($urandom_range(0, 4) != 0);
            s = build_random_string();
            send_string(s);
            sent += s.size();
        end
        sender_gaps = 1'b1;
    endtask

    initial
    begin
        int unsigned run_left;
        int unsigned hold_left;
        bit          stall_phase;
        bit          hold_taken;
        run_left    = 0;
        hold_left   = 0;
        stall_phase = 1'b0;
        hold_taken  = 1'b0;
        result_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left != 0)
            begin
                hold_left--;
            end
            else if (pressure_hold && !hold_taken)
            begin
                hold_taken   = 1'b1;
                hold_left    = LONG_HOLD - 1;
                stall_phase  = 1'b1;
                run_left     = 0;
                result_stall <= 1'b1;
            end
            else if (!receiver_stalls)
            begin
                stall_phase  = 1'b0;
                run_left     = 0;
                result_stall <= 1'b0;
            end
            else if (run_left != 0)
            begin
                run_left--;
            end
            else
            begin
                stall_phase = !stall_phase;
                if (stall_phase)
                    run_left = pick_gap();
                else
                    run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) :
                                                             $urandom_range(1, 20);
                result_stall <= stall_phase;
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        tdw_out_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (width_expect_q.size() == 0)
            begin
                report_mismatch("result with no request pending", 0, 32'(result));
            end
            else
            begin
                want = width_expect_q.pop_front();
                if (result.added_width !== want.added_width)
                    report_mismatch("added_width", 32'(want.added_width),
                                    32'(result.added_width));
                if (result.total_width !== want.total_width)
                    report_mismatch("total_width", 32'(want.total_width),
                                    32'(result.total_width));
                if (result.saturated !== want.saturated)
                    report_mismatch("saturated", 32'(want.saturated),
                                    32'(result.saturated));
                if (result.done_res !== want.done_res)
                    report_mismatch("done_res", 32'(want.done_res),
                                    32'(result.done_res));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        clear_parser();
        rst_n      <= 1'b0;
        unit_valid <= 1'b0;
        unit_data  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_character_classes();
        test_escape_sequences();
        test_surrogate_pairs();
        test_column_saturation();
        test_result_backpressure();
        test_random_strings();
        unit_valid <= 1'b0;
        while (width_expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
